// ===== src/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants for the CBOR item head encoder.
// ----------------------------------------------------------------------------
package cbe_pkg;

    typedef enum logic [2:0] {
        OP_UINT   = 3'd0,
        OP_SINT   = 3'd1,
        OP_TEXT   = 3'd2,
        OP_RAW    = 3'd3,
        OP_HALF   = 3'd4,
        OP_SINGLE = 3'd5
    } op_t;

    localparam int MAX_BYTES = 5;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // major type bits, already in bits 7..5
    localparam logic [7:0] MT_UINT = 8'h00;
    localparam logic [7:0] MT_NINT = 8'h20;
    localparam logic [7:0] MT_TEXT = 8'h60;

    // additional info codes
    localparam logic [7:0] AI_ONE  = 8'h18;
    localparam logic [7:0] AI_TWO  = 8'h19;
    localparam logic [7:0] AI_FOUR = 8'h1A;

    localparam logic [7:0] IB_HALF   = 8'hF9;
    localparam logic [7:0] IB_SINGLE = 8'hFA;

    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [7:0]  EXP_LOW   = 8'd112;
    localparam logic [7:0]  EXP_HIGH  = 8'd143;

    // encoded item, first byte in the top bits
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [CNT_W-1:0]       count;
    } enc_t;

endpackage

// ===== src/cbe_encode.sv =====
// ----------------------------------------------------------------------------
// cbe_encode
// Combinational encoder: one request in, up to five head bytes out.
// ----------------------------------------------------------------------------
module cbe_encode (
    input  logic [2:0]   op,
    input  logic [31:0]  value,
    output cbe_pkg::enc_t enc
);
    import cbe_pkg::*;

    logic [7:0]  mt;
    logic [31:0] arg;
    logic [15:0] half;
    logic [7:0]  exp_in;
    logic [7:0]  exp_reb;
    enc_t        hd;

    // major type and argument for the integer and text heads
    always_comb
    begin
        mt  = MT_UINT;
        arg = value;
        case (op)
            OP_SINT:
            begin
                if (value[31])
                begin
                    mt  = MT_NINT;
                    arg = ~value;
                end
            end
            OP_TEXT: mt = MT_TEXT;
            default: mt = MT_UINT;
        endcase
    end

    // shortest head form
    always_comb
    begin
        if (arg < 32'd24)
        begin
            hd.bytes = {mt | {3'b000, arg[4:0]}, 32'h0};
            hd.count = CNT_W'(1);
        end
        else if (arg < 32'd256)
        begin
            hd.bytes = {mt | AI_ONE, arg[7:0], 24'h0};
            hd.count = CNT_W'(2);
        end
        else if (arg < 32'd65536)
        begin
            hd.bytes = {mt | AI_TWO, arg[15:0], 16'h0};
            hd.count = CNT_W'(3);
        end
        else
        begin
            hd.bytes = {mt | AI_FOUR, arg};
            hd.count = CNT_W'(5);
        end
    end

    // single to half, truncating mantissa, flush to zero, clamp to infinity
    always_comb
    begin
        exp_in  = value[30:23];
        exp_reb = exp_in - EXP_LOW;
        if (exp_in <= EXP_LOW)
            half = {value[31], 15'h0};
        else if (exp_in >= EXP_HIGH)
            half = {value[31], HALF_INF[14:0]};
        else
            half = {value[31], exp_reb[4:0], value[22:13]};
    end

    always_comb
    begin
        case (op)
            OP_UINT, OP_SINT, OP_TEXT: enc = hd;
            OP_RAW:
            begin
                enc.bytes = {value[7:0], 32'h0};
                enc.count = CNT_W'(1);
            end
            OP_HALF:
            begin
                enc.bytes = {IB_HALF, half, 16'h0};
                enc.count = CNT_W'(3);
            end
            OP_SINGLE:
            begin
                enc.bytes = {IB_SINGLE, value};
                enc.count = CNT_W'(5);
            end
            default:
            begin
                enc.bytes = '0;
                enc.count = '0;
            end
        endcase
    end

endmodule

// ===== src/cbor_item_head_encoder.sv =====
// ----------------------------------------------------------------------------
// cbor_item_head_encoder
// Encodes one CBOR data item head per request and streams its bytes out.
// ----------------------------------------------------------------------------
// path: an accepted request is registered, then loaded into the one-byte output
//   serializer once it is empty or on its final byte, and the serializer strobes
//   its bytes; a request enters while the previous item drains
// reset: rst_n async low clears the request and serializer valid state
// the receiver cannot stall: every strobed byte is taken that cycle
module cbor_item_head_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] value,
    output logic        strobe,
    output logic [7:0]  data_byte,
    output logic        last
);
    import cbe_pkg::*;

    // request register
    logic          req_valid_reg, req_valid_next;
    logic [2:0]    req_op_reg;
    logic [31:0]   req_value_reg;

    // output serializer
    logic [8*MAX_BYTES-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    enc_t enc;
    logic accept;
    logic load;

    cbe_encode u_encode (
        .op    (req_op_reg),
        .value (req_value_reg),
        .enc   (enc)
    );

    // serializer can take a new item when empty or on its final byte
    assign load   = (cnt_reg <= CNT_W'(1));
    assign busy   = req_valid_reg && !load;
    assign accept = start && !busy;

    assign strobe    = (cnt_reg != '0);
    assign last      = (cnt_reg == CNT_W'(1));
    assign data_byte = shift_reg[8*MAX_BYTES-1 -: 8];

    always_comb
    begin
        req_valid_next = req_valid_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;

        if (load && req_valid_reg)
        begin
            // hand the encoded item over; unused opcodes give zero bytes
            shift_next     = enc.bytes;
            cnt_next       = enc.count;
            req_valid_next = 1'b0;
        end
        else if (strobe)
        begin
            shift_next = {shift_reg[8*MAX_BYTES-9:0], 8'h0};
            cnt_next   = cnt_reg - CNT_W'(1);
        end

        if (accept)
            req_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (accept)
        begin
            req_op_reg    <= op;
            req_value_reg <= value;
        end
    end

endmodule

// ===== src/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// cbe_assertions
// Port-level checks on the byte stream of the CBOR item head encoder.
// ----------------------------------------------------------------------------
module cbe_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        strobe,
    input logic        last
);

    // last byte marker only on a strobed byte
    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // an item's bytes come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside an item's bytes");

    // with the output idle a request is always taken
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe |-> !busy)
        else $error("busy while output idle");

    // a held request is released once the current item ends
    a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("busy on final byte");

endmodule

bind cbor_item_head_encoder cbe_assertions u_cbe_assertions (.*);

// ===== tb/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// cbe_checker
// Watches the request and byte channels of the CBOR item head encoder,
// predicts the encoded bytes of every accepted transaction and compares them
// in order with the strobed bytes.
// ----------------------------------------------------------------------------
module cbe_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] value,
    input  logic        strobe,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cbe_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       final_byte;
    } enc_byte_t;

    enc_byte_t expected_bytes[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // single to half, mantissa truncated, out of range saturates
    function automatic logic [15:0] half_from_single(input logic [31:0] f);
        logic [7:0]  e;
        logic [15:0] s;
        e = f[30:23];
        s = {f[31], 15'd0};
        if (e <= EXP_LOW)
            return s;
        if (e >= EXP_HIGH)
            return s | HALF_INF;
        return s | {1'b0, 5'(e - EXP_LOW), f[22:13]};
    endfunction

    // shortest head, bytes packed from the top
    function automatic int head_bytes(input logic [7:0] major, input logic [31:0] arg,
                                      output logic [39:0] enc);
        enc = '0;
        if (arg < 32'd24)
        begin
            enc[39:32] = major | arg[7:0];
            return 1;
        end
        if (arg < 32'd256)
        begin
            enc[39:24] = {major | AI_ONE, arg[7:0]};
            return 2;
        end
        if (arg < 32'd65536)
        begin
            enc[39:16] = {major | AI_TWO, arg[15:0]};
            return 3;
        end
        enc = {major | AI_FOUR, arg};
        return 5;
    endfunction

    function automatic int item_encoding(input logic [2:0] code, input logic [31:0] v,
                                         output logic [39:0] enc);
        int n;
        enc = '0;
        n   = 0;
        case (code)
            OP_UINT:   n = head_bytes(MT_UINT, v, enc);
            OP_SINT:
            begin
                if (v[31])
                    n = head_bytes(MT_NINT, ~v, enc);
                else
                    n = head_bytes(MT_UINT, v, enc);
            end
            OP_TEXT:   n = head_bytes(MT_TEXT, v, enc);
            OP_RAW:
            begin
                enc[39:32] = v[7:0];
                n = 1;
            end
            OP_HALF:
            begin
                enc[39:16] = {IB_HALF, half_from_single(v)};
                n = 3;
            end
            OP_SINGLE:
            begin
                enc = {IB_SINGLE, v};
                n = 5;
            end
            default:   n = 0;
        endcase
        return n;
    endfunction

    always @(posedge clk)
    begin : watch
        enc_byte_t   want;
        logic [39:0] enc;
        int          n;
        if (rst_n)
        begin
            // a byte strobed at this edge never belongs to a transaction accepted here
            if (strobe)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte %02h (last %0b) with nothing pending",
                           data_byte, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (data_byte !== want.data)
                    begin
                        $error("data_byte mismatch: expected %02h, got %02h",
                               want.data, data_byte);
                        fail_count++;
                    end
                    if (last !== want.final_byte)
                    begin
                        $error("last mismatch: expected %0b, got %0b", want.final_byte, last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                n = item_encoding(op, value, enc);
                for (int i = 0; i < n; i++)
                    expected_bytes.push_back({enc[39-8*i -: 8], i == n - 1});
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random requests into the CBOR item head encoder with
// random idle gaps; a checker beside the block predicts and compares every
// byte, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cbe_pkg::*;

    // opcodes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 325;
    // no idle gaps while the random count is in this window
    localparam int QUIET_FROM   = 130;
    localparam int QUIET_TO     = 210;
    // watchdog bound, far beyond the slowest run
    localparam int CYCLE_LIMIT  = 60000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  op    = '0;
    logic [31:0] value = '0;
    logic        busy;
    logic        strobe;
    logic [7:0]  data_byte;
    logic        last;
    int          fail_count;
    int          pending;
    int unsigned cycles = 0;

    cbor_item_head_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .strobe    (strobe),
        .data_byte (data_byte),
        .last      (last)
    );

    cbe_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .value      (value),
        .strobe     (strobe),
        .data_byte  (data_byte),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost byte ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // integer argument spread over all head sizes and their boundaries
    function automatic logic [31:0] rand_arg();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom_range(23);
            1: v = $urandom_range(255, 24);
            2: v = $urandom_range(65535, 256);
            3: v = $urandom;
            default:
            begin
                case ($urandom_range(6))
                    0: v = 32'd23;
                    1: v = 32'd24;
                    2: v = 32'd255;
                    3: v = 32'd256;
                    4: v = 32'd65535;
                    5: v = 32'd65536;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // float32 bits with the exponent often near the half range edges
    function automatic logic [31:0] rand_single_bits();
        logic [7:0] e;
        case ($urandom_range(3))
            0: e = 8'($urandom_range(255));
            1: e = 8'($urandom_range(116, 108));
            2: e = 8'($urandom_range(147, 139));
            default: e = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        return {1'($urandom_range(1)), e, 23'($urandom)};
    endfunction

    function automatic logic [31:0] rand_value(input logic [2:0] code);
        logic [31:0] v;
        case (code)
            OP_UINT, OP_TEXT: v = rand_arg();
            OP_SINT:
            begin
                // complementing mirrors every argument class onto the negatives
                v = rand_arg();
                if ($urandom_range(1))
                    v = ~v;
            end
            OP_HALF: v = rand_single_bits();
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // present one transaction from a falling edge and hold it until taken
    task automatic drive_item(input logic [2:0] code, input logic [31:0] v);
        start = 1'b1;
        op    = code;
        value = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random sender idle, with junk on the payload while start is low
    task automatic sender_gap(input bit quiet);
        if (!quiet && $urandom_range(99) < 22)
        begin
            start = 1'b0;
            op    = 3'($urandom);
            value = $urandom;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        int          sent;
        logic [2:0]  code;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // integer heads at every size boundary
        drive_item(OP_UINT, 32'd0);           sender_gap(1'b0);
        drive_item(OP_UINT, 32'd23);          sender_gap(1'b0);
        drive_item(OP_UINT, 32'd24);          sender_gap(1'b0);
        drive_item(OP_UINT, 32'd255);         sender_gap(1'b0);
        drive_item(OP_UINT, 32'd256);         sender_gap(1'b0);
        drive_item(OP_UINT, 32'd65535);       sender_gap(1'b0);
        drive_item(OP_UINT, 32'd65536);       sender_gap(1'b0);
        drive_item(OP_UINT, 32'hFFFF_FFFF);   sender_gap(1'b0);
        // signed: largest positive goes out as unsigned, negatives as complement
        drive_item(OP_SINT, 32'h7FFF_FFFF);   sender_gap(1'b0);
        drive_item(OP_SINT, 32'hFFFF_FFFF);   sender_gap(1'b0);
        drive_item(OP_SINT, 32'hFFFF_FFE8);   sender_gap(1'b0);
        drive_item(OP_SINT, 32'hFFFF_FFE7);   sender_gap(1'b0);
        drive_item(OP_SINT, 32'h8000_0000);   sender_gap(1'b0);
        drive_item(OP_TEXT, 32'd300);         sender_gap(1'b0);
        // raw byte ignores the upper bits
        drive_item(OP_RAW, 32'hABCD_EF5A);    sender_gap(1'b0);
        // half: normal, negative zero, exponent just above underflow,
        // largest finite, exponent overflow, infinity, negative nan
        drive_item(OP_HALF, 32'h3F80_0000);   sender_gap(1'b0);
        drive_item(OP_HALF, 32'h8000_0000);   sender_gap(1'b0);
        drive_item(OP_HALF, 32'h3880_0000);   sender_gap(1'b0);
        drive_item(OP_HALF, 32'h477F_E000);   sender_gap(1'b0);
        drive_item(OP_HALF, 32'h4780_0000);   sender_gap(1'b0);
        drive_item(OP_HALF, 32'h7F80_0000);   sender_gap(1'b0);
        drive_item(OP_HALF, 32'hFFC0_0001);   sender_gap(1'b0);
        drive_item(OP_SINGLE, 32'hC0490FDB);  sender_gap(1'b0);
        // ignored opcodes must produce nothing
        drive_item(OP_SPARE_A, 32'd5);        sender_gap(1'b0);
        drive_item(OP_SPARE_B, 32'hFFFF_FFFF); sender_gap(1'b0);

        // random part; ignored opcodes are sprinkled in but not counted
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 3)
                code = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
            else
                code = 3'($urandom_range(OP_SINGLE));
            drive_item(code, rand_value(code));
            if (code <= OP_SINGLE)
                sent++;
            sender_gap(sent >= QUIET_FROM && sent < QUIET_TO);
        end
        start = 1'b0;

        // let every predicted byte arrive, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cbe_pkg.sv
src/cbe_encode.sv
src/cbor_item_head_encoder.sv
src/cbe_checker.sv
tb/cbe_checker.sv
tb/tb_top.sv
